/* design/assert_macros.svh */
// Assertion macros used by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/drcs_pkg.sv */
// Constants, types and angle table of the double-rotation CORDIC sine/cosine core.
`timescale 1ns / 1ps
package drcs_pkg;

  localparam int ITERATIONS    = 16;
  localparam int FRACTION_BITS = 16;

  localparam int IN_W   = 17;
  localparam int OUT_W  = 18;
  localparam int DP_W   = (FRACTION_BITS + 4 > IN_W + 2) ? FRACTION_BITS + 4 : IN_W + 2;
  localparam int IDX_W  = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
  localparam int SH_W   = IDX_W + 2;
  localparam int EXT_W  = ((DP_W > OUT_W) ? DP_W : OUT_W) + 1;

  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam longint K_INIT = ((longint'(9219) << FRACTION_BITS) + 5000) / 10000;

  localparam int ATAN_SH = 30 - FRACTION_BITS;
  localparam logic [63:0] ATAN_RND = (64'd1 << ATAN_SH) >> 1;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [DP_W-1:0] x;
    logic signed [DP_W-1:0] y;
    logic signed [DP_W-1:0] z;
  } drcs_vec_t;

  typedef struct packed {
    logic      valid;
    drcs_vec_t vec;
  } drcs_stage_t;

  function automatic logic signed [DP_W-1:0] step_angle(logic [IDX_W-1:0] idx);
    logic [4:0]  j;
    logic [63:0] a;
    j = 5'({1'b0, idx} + 2);
    a = {31'b0, ATAN_Q30[j], 1'b0};
    a = (a + ATAN_RND) >> ATAN_SH;
    return DP_W'(a);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [DP_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > EXT_W'((longint'(1) << (OUT_W - 1)) - 1)) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end else if (e < -EXT_W'(longint'(1) << (OUT_W - 1))) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return OUT_W'(e);
  endfunction

endpackage

/* design/drcs_cell.sv */
// One double-rotation CORDIC step, registered.
`timescale 1ns / 1ps
module drcs_cell import drcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [IDX_W-1:0] idx_i,
  input  drcs_stage_t      stage_i,
  output drcs_stage_t      stage_o
);

  logic                   valid_q;
  drcs_vec_t              vec_q;
  drcs_vec_t              vec_d;
  logic [SH_W-1:0]        sh1;
  logic [SH_W-1:0]        sh2;
  logic signed [DP_W-1:0] xs, ys, xc, yc, a;

  always_comb begin
    sh1 = SH_W'(idx_i) + SH_W'(1);
    sh2 = (SH_W'(idx_i) << 1) + SH_W'(4);
    xs  = stage_i.vec.x >>> sh1;
    ys  = stage_i.vec.y >>> sh1;
    xc  = stage_i.vec.x >>> sh2;
    yc  = stage_i.vec.y >>> sh2;
    a   = step_angle(idx_i);
    if (stage_i.vec.z < 0) begin
      vec_d.x = stage_i.vec.x + ys - xc;
      vec_d.y = stage_i.vec.y - xs - yc;
      vec_d.z = stage_i.vec.z + a;
    end else begin
      vec_d.x = stage_i.vec.x - ys - xc;
      vec_d.y = stage_i.vec.y + xs - yc;
      vec_d.z = stage_i.vec.z - a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.vec   = vec_q;

endmodule

/* design/double_rotation_cordic_sincos_core.sv */
// Top level of the double-rotation CORDIC sine/cosine core.
// One angle (Q1.16 radians) is taken per cycle unless the output is held off;
// cosine, sine and the leftover angle pass through one cell per CORDIC step
// in a row, then a saturating output register.
// When the output transaction is held off, the whole row freezes and
// s_axis_tready drops in the same cycle. No reset clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module double_rotation_cordic_sincos_core import drcs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // angle[16:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // cosine, sine, residual_angle
);

  drcs_stage_t            chain [ITERATIONS+1];
  logic                   advance;
  logic                   out_valid_q;
  logic signed [OUT_W-1:0] cos_q, sin_q, res_q;
  logic signed [IN_W-1:0] angle;

  assign advance = !out_valid_q || m_axis_tready;
  assign angle   = s_axis_tdata[IN_W-1:0];

  assign chain[0].valid = s_axis_tvalid;
  assign chain[0].vec.x = DP_W'(K_INIT);
  assign chain[0].vec.y = '0;
  assign chain[0].vec.z = DP_W'(angle);

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    drcs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .idx_i   (IDX_W'(g)),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= chain[ITERATIONS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cos_q <= sat_out(chain[ITERATIONS].vec.x);
      sin_q <= sat_out(chain[ITERATIONS].vec.y);
      res_q <= sat_out(chain[ITERATIONS].vec.z);
    end
  end

  assign s_axis_tready = advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - 3 * OUT_W)'(0), res_q, sin_q, cos_q};

  `ASSERT_NEXT(a_enter_first_cell, clk_i, rst_ni,
               s_axis_tvalid && s_axis_tready, chain[1].valid)
  `ASSERT_NEXT(a_last_cell_to_out, clk_i, rst_ni,
               s_axis_tready && chain[ITERATIONS].valid, m_axis_tvalid)
  `ASSERT_NEXT(a_stall_freezes_row, clk_i, rst_ni,
               !s_axis_tready, $stable(chain[1].valid) && $stable(chain[ITERATIONS].valid))

endmodule

/* tb/testbench.sv */
// Self-checking stream testbench for the double-rotation CORDIC sine/cosine core.
`timescale 1ns / 1ps
module testbench;
  import drcs_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] cosine;
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] residual;
  } sincos_t;

  class sincos_scoreboard;
    sincos_t pending_sincos[$];
    int      errors;
    int      angles_seen;
    int      results_checked;

    function new();
      errors = 0;
      angles_seen = 0;
      results_checked = 0;
    endfunction

    function logic signed [OUT_W-1:0] clip_out(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (OUT_W - 1)) - 1;
      lo = -(longint'(1) << (OUT_W - 1));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return OUT_W'(v);
    endfunction

    function sincos_t cordic_sincos(logic signed [IN_W-1:0] angle);
      longint  x;
      longint  y;
      longint  z;
      longint  xs;
      longint  ys;
      longint  xc;
      longint  yc;
      longint  a;
      int      sh;
      sincos_t r;
      sh = 30 - FRACTION_BITS;
      z = angle;
      x = ((longint'(9219) << FRACTION_BITS) + 5000) / 10000;
      y = 0;
      for (int i = 0; i < ITERATIONS; i++) begin
        xs = x >>> (i + 1);
        ys = y >>> (i + 1);
        xc = x >>> (2 * i + 4);
        yc = y >>> (2 * i + 4);
        a = longint'(ATAN_Q30[(i + 2) % 32]) * 2;
        if (sh > 0) a = (a + (longint'(1) << (sh - 1))) >>> sh;
        if (z < 0) begin
          x = x + ys - xc;
          y = y - xs - yc;
          z = z + a;
        end else begin
          x = x - ys - xc;
          y = y + xs - yc;
          z = z - a;
        end
      end
      r.cosine   = clip_out(x);
      r.sine     = clip_out(y);
      r.residual = clip_out(z);
      return r;
    endfunction

    function void note_angle(logic signed [IN_W-1:0] angle);
      pending_sincos.push_back(cordic_sincos(angle));
      angles_seen++;
    endfunction

    function int outstanding();
      return pending_sincos.size();
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      sincos_t want;
      sincos_t got;
      got.cosine   = tdata[OUT_W-1:0];
      got.sine     = tdata[2*OUT_W-1:OUT_W];
      got.residual = tdata[3*OUT_W-1:2*OUT_W];
      if (pending_sincos.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cos %0d sin %0d res %0d",
                 $time, got.cosine, got.sine, got.residual);
        errors++;
        return;
      end
      want = pending_sincos.pop_front();
      results_checked++;
      if (got.cosine !== want.cosine) begin
        $display("%0t: cosine mismatch, expected %0d actual %0d",
                 $time, want.cosine, got.cosine);
        errors++;
      end
      if (got.sine !== want.sine) begin
        $display("%0t: sine mismatch, expected %0d actual %0d", $time, want.sine, got.sine);
        errors++;
      end
      if (got.residual !== want.residual) begin
        $display("%0t: residual mismatch, expected %0d actual %0d",
                 $time, want.residual, got.residual);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  bit               idle_en = 1'b1;
  sincos_scoreboard sb = new();

  double_rotation_cordic_sincos_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_angle(s_axis_tdata[IN_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // hold off the result side in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_angle(input logic [IN_W-1:0] angle);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(angle);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    logic signed [IN_W-1:0] angle;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85)
        angle = IN_W'($signed($urandom_range(0, 2 * 51472)) - 51472);
      else
        angle = IN_W'($urandom());
      send_angle(angle);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [IN_W-1:0] directed[$];
    directed = '{17'sd0, 17'sd1, -17'sd1, 17'sd2, -17'sd2, 17'sd51472, -17'sd51472,
                 17'sd65535, -17'sd65536, 17'sd25736, -17'sd25736, 17'sd12868,
                 -17'sd12868, 17'sd32768, -17'sd32768, 17'sd60000, -17'sd60000,
                 17'sd43690, -17'sd43691, 17'sd51473, -17'sd51473, 17'sd100};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[k]) send_angle(directed[k]);
    send_random(400);
    drain_results();
    idle_en = 1'b0;
    send_random(200);
    idle_en = 1'b1;
    send_random(300);
    idle_en = 1'b0;
    send_random(100);
    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d angles (directed extremes, zero, out-of-range and random).",
             sb.angles_seen);
    $display("Checked %0d results under random source gaps and sink stalls.",
             sb.results_checked);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", sb.outstanding());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
